>>> rtl/spi_nand_write_combining_sequencer_defines.svh
// ----------------------------------------------------------------------------
// SPI NAND write-combining sequencer: assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef SPI_NAND_WRITE_COMBINING_SEQUENCER_DEFINES_SVH
`define SPI_NAND_WRITE_COMBINING_SEQUENCER_DEFINES_SVH

// same-cycle implication
`define SNWC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SNWC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/snwc_pkg.sv
// ----------------------------------------------------------------------------
// snwc_pkg
// Types, command codes, opcodes and slot positions shared by the sequencer.
// ----------------------------------------------------------------------------
package snwc_pkg;

    localparam int ADDR_W    = 32;
    localparam int ROW_W     = 24;
    localparam int COL_W     = 12;
    localparam int CNT_W     = 13;
    localparam int SLOTS     = 7;
    localparam int SLOT_W    = 3;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;
    localparam int Q_COUNT_W = 2;

    typedef enum logic [2:0] {
        CMD_WRITE = 3'd0,
        CMD_READ  = 3'd1,
        CMD_ERASE = 3'd2,
        CMD_FLUSH = 3'd3,
        CMD_ECC   = 3'd4
    } cmd_t;

    localparam logic CFG_PAGE_LOG  = 1'b0;
    localparam logic CFG_BLOCK_LOG = 1'b1;

    localparam logic [7:0] OP_PAGE_READ    = 8'h13;
    localparam logic [7:0] OP_READ_CACHE   = 8'h03;
    localparam logic [7:0] OP_RANDOM_LOAD  = 8'h84;
    localparam logic [7:0] OP_PROGRAM_LOAD = 8'h02;
    localparam logic [7:0] OP_PROGRAM_EXEC = 8'h10;
    localparam logic [7:0] OP_BLOCK_ERASE  = 8'hD8;
    localparam logic [7:0] OP_WRITE_ENABLE = 8'h06;
    localparam logic [7:0] OP_GET_FEATURE  = 8'h0F;
    localparam logic [7:0] OP_SET_FEATURE  = 8'h1F;
    localparam logic [7:0] OP_RESET        = 8'hFF;

    localparam logic [7:0] FEAT_STATUS    = 8'hC0;
    localparam logic [7:0] FEAT_LOCK      = 8'hA0;
    localparam logic [7:0] FEAT_CONFIG    = 8'hB0;
    localparam logic [7:0] LOCK_NONE      = 8'h00;
    localparam logic [7:0] CONFIG_ECC_ON  = 8'h10;

    // write
    localparam logic [SLOT_W-1:0] WR_POLL    = 3'd0;
    localparam logic [SLOT_W-1:0] WR_WEN     = 3'd1;
    localparam logic [SLOT_W-1:0] WR_LOAD    = 3'd2;
    localparam logic [SLOT_W-1:0] WR_POLL_EX = 3'd3;
    localparam logic [SLOT_W-1:0] WR_WEN_EX  = 3'd4;
    localparam logic [SLOT_W-1:0] WR_POLL_PG = 3'd5;
    localparam logic [SLOT_W-1:0] WR_EXEC    = 3'd6;
    // read
    localparam logic [SLOT_W-1:0] RD_POLL_EX   = 3'd0;
    localparam logic [SLOT_W-1:0] RD_EXEC      = 3'd1;
    localparam logic [SLOT_W-1:0] RD_POLL_PG   = 3'd2;
    localparam logic [SLOT_W-1:0] RD_PAGE      = 3'd3;
    localparam logic [SLOT_W-1:0] RD_POLL_RD   = 3'd4;
    localparam logic [SLOT_W-1:0] RD_POLL_LAST = 3'd5;
    localparam logic [SLOT_W-1:0] RD_CACHE     = 3'd6;
    // erase
    localparam logic [SLOT_W-1:0] ER_POLL  = 3'd0;
    localparam logic [SLOT_W-1:0] ER_WEN   = 3'd1;
    localparam logic [SLOT_W-1:0] ER_ERASE = 3'd2;
    // flush
    localparam logic [SLOT_W-1:0] FL_POLL = 3'd0;
    localparam logic [SLOT_W-1:0] FL_EXEC = 3'd1;
    // ecc recovery
    localparam logic [SLOT_W-1:0] EC_RESET  = 3'd0;
    localparam logic [SLOT_W-1:0] EC_POLL   = 3'd1;
    localparam logic [SLOT_W-1:0] EC_LOCK   = 3'd2;
    localparam logic [SLOT_W-1:0] EC_CONFIG = 3'd3;

    typedef struct packed {
        logic [2:0]        command;
        logic [ADDR_W-1:0] address;
        logic [CNT_W-1:0]  length;
        logic [2:0]        ecc_code;
    } req_t;

    typedef struct packed {
        logic [7:0]       opcode;
        logic [ROW_W-1:0] row_address;
        logic [COL_W-1:0] column;
        logic [CNT_W-1:0] byte_count;
        logic [7:0]       feature_addr;
        logic [7:0]       feature_value;
        logic             last;
    } word_t;

    typedef struct packed {
        logic [3:0] page_log;
        logic [3:0] block_log;
    } cfg_t;

    typedef struct packed {
        cmd_t             kind;
        logic [SLOTS-1:0] mask;
        logic             random;
        logic [ROW_W-1:0] row_exec;
        logic [ROW_W-1:0] row_b;
        logic [COL_W-1:0] column;
        logic [CNT_W-1:0] count;
    } desc_t;

endpackage

>>> rtl/snwc_front.sv
// ----------------------------------------------------------------------------
// snwc_front
// Request decode: tracks cache and device state, turns each request into a
// descriptor of the command words to send.
// ----------------------------------------------------------------------------
`include "spi_nand_write_combining_sequencer_defines.svh"

module snwc_front #(
    parameter int ADDR_BITS = 32,
    parameter int ROW_BITS  = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    input  snwc_pkg::cfg_t  cfg,
    input  logic            req_valid,
    input  snwc_pkg::req_t  req,
    input  logic            q_full,
    output logic            push,
    output snwc_pkg::desc_t desc
);
    import snwc_pkg::*;

    localparam logic [ROW_W-1:0] ROW_MASK = ROW_W'((64'd1 << ROW_BITS) - 64'd1);

    function automatic logic [ROW_W-1:0] page_of(input logic [ADDR_BITS-1:0] a,
                                                 input logic [3:0] p);
        logic [ADDR_BITS-1:0] sh;
        case (p)
            4'd9:    sh = a >> 9;
            4'd10:   sh = a >> 10;
            4'd11:   sh = a >> 11;
            default: sh = a >> 12;
        endcase
        return ROW_W'(sh) & ROW_MASK;
    endfunction

    function automatic logic [CNT_W-1:0] page_bytes(input logic [3:0] p);
        logic [CNT_W-1:0] n;
        case (p)
            4'd9:    n = 13'd512;
            4'd10:   n = 13'd1024;
            4'd11:   n = 13'd2048;
            default: n = 13'd4096;
        endcase
        return n;
    endfunction

    function automatic logic [ROW_W-1:0] blk_mask(input logic [3:0] b);
        logic [ROW_W-1:0] m;
        case (b)
            4'd4:    m = 24'h00000F;
            4'd5:    m = 24'h00001F;
            4'd6:    m = 24'h00003F;
            4'd7:    m = 24'h00007F;
            default: m = 24'h0000FF;
        endcase
        return m;
    endfunction

    logic                 dirty_reg, dirty_next;
    logic [ADDR_BITS-1:0] load_reg, load_next;
    logic [ADDR_BITS-1:0] start_reg, start_next;
    logic [ROW_W-1:0]     open_reg, open_next;
    logic                 open_valid_reg, open_valid_next;
    logic                 busy_reg, busy_next;

    logic                 acc;
    logic [ADDR_BITS-1:0] addr_m;
    logic [ADDR_BITS-1:0] wr_base, wr_start, wr_load;
    logic [CNT_W-1:0]     pg_bytes, wr_room, wr_len, rd_room, rd_cnt;
    logic [COL_W-1:0]     col_mask, wr_col, rd_col;
    logic                 wr_fill, rd_valid, rd_change, rd_touch;
    logic [ROW_W-1:0]     exec_row, tgt_row, erase_row, rd_open;

    assign acc      = req_valid && !q_full;
    assign addr_m   = req.address[ADDR_BITS-1:0];
    assign wr_base  = dirty_reg ? load_reg : addr_m;
    assign wr_start = dirty_reg ? start_reg : addr_m;
    assign pg_bytes = page_bytes(cfg.page_log);
    assign col_mask = COL_W'(pg_bytes - 13'd1);

    assign wr_col  = wr_base[COL_W-1:0] & col_mask;
    assign wr_room = pg_bytes - {1'b0, wr_col};
    assign wr_fill = req.length >= wr_room;
    assign wr_len  = wr_fill ? wr_room : req.length;
    assign wr_load = wr_base + ADDR_BITS'(wr_len);

    assign exec_row  = page_of(wr_start, cfg.page_log);
    assign tgt_row   = page_of(addr_m, cfg.page_log);
    assign erase_row = tgt_row & ~blk_mask(cfg.block_log);

    assign rd_col    = addr_m[COL_W-1:0] & col_mask;
    assign rd_room   = pg_bytes - {1'b0, rd_col};
    assign rd_cnt    = (req.length < rd_room) ? req.length : rd_room;
    assign rd_open   = dirty_reg ? exec_row : open_reg;
    assign rd_valid  = dirty_reg || open_valid_reg;
    assign rd_change = !rd_valid || (rd_open != tgt_row);
    assign rd_touch  = dirty_reg || rd_change;

    always_comb
    begin
        desc            = '0;
        dirty_next      = dirty_reg;
        load_next       = load_reg;
        start_next      = start_reg;
        open_next       = open_reg;
        open_valid_next = open_valid_reg;
        busy_next       = busy_reg;
        case (req.command)
            CMD_WRITE:
            begin
                if (req.length != '0)
                begin
                    desc.kind             = CMD_WRITE;
                    desc.mask[WR_POLL]    = busy_reg;
                    desc.mask[WR_WEN]     = 1'b1;
                    desc.mask[WR_LOAD]    = 1'b1;
                    desc.mask[WR_POLL_EX] = wr_fill;
                    desc.mask[WR_WEN_EX]  = wr_fill;
                    desc.mask[WR_POLL_PG] = wr_fill;
                    desc.mask[WR_EXEC]    = wr_fill;
                    desc.random           = dirty_reg;
                    desc.column           = wr_col;
                    desc.count            = wr_len;
                    desc.row_exec         = exec_row;
                    load_next             = wr_load;
                    busy_next             = 1'b1;
                    if (wr_fill)
                    begin
                        open_next       = exec_row;
                        open_valid_next = 1'b1;
                        dirty_next      = 1'b0;
                        start_next      = wr_load;
                    end
                    else
                    begin
                        dirty_next = 1'b1;
                        start_next = wr_start;
                    end
                end
            end
            CMD_READ:
            begin
                desc.kind               = CMD_READ;
                desc.mask[RD_POLL_EX]   = dirty_reg && busy_reg;
                desc.mask[RD_EXEC]      = dirty_reg;
                desc.mask[RD_POLL_PG]   = rd_touch && (dirty_reg || busy_reg);
                desc.mask[RD_PAGE]      = rd_change;
                desc.mask[RD_POLL_RD]   = rd_change;
                desc.mask[RD_POLL_LAST] = !rd_touch && busy_reg;
                desc.mask[RD_CACHE]     = 1'b1;
                desc.row_exec           = exec_row;
                desc.row_b              = tgt_row;
                desc.column             = rd_col;
                desc.count              = rd_cnt;
                dirty_next              = 1'b0;
                open_next               = rd_change ? tgt_row : rd_open;
                open_valid_next         = 1'b1;
                busy_next               = 1'b0;
            end
            CMD_ERASE:
            begin
                desc.kind           = CMD_ERASE;
                desc.mask[ER_POLL]  = busy_reg;
                desc.mask[ER_WEN]   = 1'b1;
                desc.mask[ER_ERASE] = 1'b1;
                desc.row_b          = erase_row;
                busy_next           = 1'b1;
            end
            CMD_FLUSH:
            begin
                if (dirty_reg)
                begin
                    desc.kind          = CMD_FLUSH;
                    desc.mask[FL_POLL] = busy_reg;
                    desc.mask[FL_EXEC] = 1'b1;
                    desc.row_exec      = exec_row;
                    open_next          = exec_row;
                    open_valid_next    = 1'b1;
                    dirty_next         = 1'b0;
                    busy_next          = 1'b1;
                end
            end
            CMD_ECC:
            begin
                if (req.ecc_code >= 3'd1 && req.ecc_code <= 3'd3)
                begin
                    desc.kind            = CMD_ECC;
                    desc.mask[EC_RESET]  = 1'b1;
                    desc.mask[EC_POLL]   = 1'b1;
                    desc.mask[EC_LOCK]   = 1'b1;
                    desc.mask[EC_CONFIG] = 1'b1;
                    busy_next            = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign push = acc && (desc.mask != '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dirty_reg      <= 1'b0;
            load_reg       <= '0;
            start_reg      <= '0;
            open_reg       <= '0;
            open_valid_reg <= 1'b0;
            busy_reg       <= 1'b1;
        end
        else if (acc)
        begin
            dirty_reg      <= dirty_next;
            load_reg       <= load_next;
            start_reg      <= start_next;
            open_reg       <= open_next;
            open_valid_reg <= open_valid_next;
            busy_reg       <= busy_next;
        end
    end

    `SNWC_ASSERT_NEXT(a_read_settles, acc && req.command == CMD_READ, !dirty_reg && open_valid_reg && !busy_reg, "read left cache dirty or device busy")
    `SNWC_ASSERT_NEXT(a_write_marks, acc && req.command == CMD_WRITE && req.length != '0, busy_reg && (dirty_reg || open_valid_reg), "write left no cached page")

endmodule

>>> rtl/snwc_queue.sv
// ----------------------------------------------------------------------------
// snwc_queue
// Short descriptor queue between request decode and word issue.
// ----------------------------------------------------------------------------
`include "spi_nand_write_combining_sequencer_defines.svh"

module snwc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  snwc_pkg::desc_t push_data,
    output logic            full,
    input  logic            pop,
    output snwc_pkg::desc_t pop_data,
    output logic            empty
);
    import snwc_pkg::*;

    desc_t                entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_COUNT_W-1:0] count_reg, count_next;

    assign full     = count_reg == Q_COUNT_W'(Q_DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    `SNWC_ASSERT_NOW(a_push_room, push, !full, "push into full queue")
    `SNWC_ASSERT_NOW(a_pop_data, pop, !empty, "pop from empty queue")

endmodule

>>> rtl/snwc_back.sv
// ----------------------------------------------------------------------------
// snwc_back
// Word issue: walks the slots of each descriptor and sends one command word
// per cycle while word_stall is low, through a registered output.
// ----------------------------------------------------------------------------
`include "spi_nand_write_combining_sequencer_defines.svh"

module snwc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_empty,
    input  snwc_pkg::desc_t q_data,
    output logic            q_pop,
    output logic            word_valid,
    input  logic            word_stall,
    output snwc_pkg::word_t word
);
    import snwc_pkg::*;

    function automatic word_t poll_word();
        word_t w;
        w              = '0;
        w.opcode       = OP_GET_FEATURE;
        w.feature_addr = FEAT_STATUS;
        return w;
    endfunction

    function automatic word_t build_word(input desc_t d, input logic [SLOT_W-1:0] slot,
                                         input logic last);
        word_t w;
        w = '0;
        case (d.kind)
            CMD_WRITE:
            begin
                case (slot)
                    WR_POLL, WR_POLL_EX, WR_POLL_PG: w = poll_word();
                    WR_WEN, WR_WEN_EX:               w.opcode = OP_WRITE_ENABLE;
                    WR_LOAD:
                    begin
                        w.opcode     = d.random ? OP_RANDOM_LOAD : OP_PROGRAM_LOAD;
                        w.column     = d.column;
                        w.byte_count = d.count;
                    end
                    WR_EXEC:
                    begin
                        w.opcode      = OP_PROGRAM_EXEC;
                        w.row_address = d.row_exec;
                    end
                    default: w = '0;
                endcase
            end
            CMD_READ:
            begin
                case (slot)
                    RD_POLL_EX, RD_POLL_PG, RD_POLL_RD, RD_POLL_LAST: w = poll_word();
                    RD_EXEC:
                    begin
                        w.opcode      = OP_PROGRAM_EXEC;
                        w.row_address = d.row_exec;
                    end
                    RD_PAGE:
                    begin
                        w.opcode      = OP_PAGE_READ;
                        w.row_address = d.row_b;
                    end
                    RD_CACHE:
                    begin
                        w.opcode     = OP_READ_CACHE;
                        w.column     = d.column;
                        w.byte_count = d.count;
                    end
                    default: w = '0;
                endcase
            end
            CMD_ERASE:
            begin
                case (slot)
                    ER_POLL: w = poll_word();
                    ER_WEN:  w.opcode = OP_WRITE_ENABLE;
                    ER_ERASE:
                    begin
                        w.opcode      = OP_BLOCK_ERASE;
                        w.row_address = d.row_b;
                    end
                    default: w = '0;
                endcase
            end
            CMD_FLUSH:
            begin
                case (slot)
                    FL_POLL: w = poll_word();
                    FL_EXEC:
                    begin
                        w.opcode      = OP_PROGRAM_EXEC;
                        w.row_address = d.row_exec;
                    end
                    default: w = '0;
                endcase
            end
            CMD_ECC:
            begin
                case (slot)
                    EC_RESET: w.opcode = OP_RESET;
                    EC_POLL:  w = poll_word();
                    EC_LOCK:
                    begin
                        w.opcode        = OP_SET_FEATURE;
                        w.feature_addr  = FEAT_LOCK;
                        w.feature_value = LOCK_NONE;
                    end
                    EC_CONFIG:
                    begin
                        w.opcode        = OP_SET_FEATURE;
                        w.feature_addr  = FEAT_CONFIG;
                        w.feature_value = CONFIG_ECC_ON;
                    end
                    default: w = '0;
                endcase
            end
            default: w = '0;
        endcase
        w.last = last;
        return w;
    endfunction

    logic             cur_valid_reg;
    desc_t            cur_reg;
    logic [SLOTS-1:0] rem_reg, rem_after;
    logic             word_valid_reg;
    word_t            word_reg;

    logic [SLOT_W-1:0] slot;
    logic              last, advance, done;

    always_comb
    begin
        slot = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (rem_reg[i])
            begin
                slot = SLOT_W'(i);
            end
        end
    end

    assign rem_after = rem_reg & (rem_reg - 1'b1);
    assign last      = rem_after == '0;
    assign advance   = cur_valid_reg && (!word_valid_reg || !word_stall);
    assign done      = !cur_valid_reg || (advance && last);
    assign q_pop     = !q_empty && done;

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_data;
        end
        if (advance)
        begin
            word_reg <= build_word(cur_reg, slot, last);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            rem_reg        <= '0;
            word_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                rem_reg       <= q_data.mask;
            end
            else if (advance)
            begin
                cur_valid_reg <= !last;
                rem_reg       <= rem_after;
            end
            if (advance)
            begin
                word_valid_reg <= 1'b1;
            end
            else if (!word_stall)
            begin
                word_valid_reg <= 1'b0;
            end
        end
    end

    assign word_valid = word_valid_reg;
    assign word       = word_reg;

    `SNWC_ASSERT_NOW(a_cur_has_work, cur_valid_reg, rem_reg != '0, "active descriptor with no slots")
    `SNWC_ASSERT_NEXT(a_last_drains, advance && last && !q_pop, !cur_valid_reg, "descriptor kept after last word")

endmodule

>>> rtl/spi_nand_write_combining_sequencer.sv
// ----------------------------------------------------------------------------
// spi_nand_write_combining_sequencer
// Turns write, read, erase, flush and ECC-report requests into SPI NAND
// command words, combining writes in the device page cache.
// ----------------------------------------------------------------------------
// Requests arrive on req/req_valid/req_stall; command words leave on
// word/word_valid/word_stall, one transfer per word, with last set on the
// final word of each request. A transfer happens when valid is high and
// stall is low.
// The decode stage takes one request per cycle while its two-entry
// descriptor queue has room. The issue stage sends one word per cycle while
// word_stall is low. A request makes up to 7 words for a write that fills
// a page, 6 for a read, 3 for an erase, 2 for a flush and 4 for an ECC
// recovery; a request that makes none pushes no descriptor.
// The first word of a request goes through the queue, cur_reg and word_reg.
// A stalled word holds; the queue then fills and req_stall rises.
// Reset: clean cache, no open page, device assumed busy, 2048-byte pages,
// 64 pages per block. No clearing pass. Configuration writes (cfg_we) are
// registered and clamped to the supported range.
// ----------------------------------------------------------------------------
module spi_nand_write_combining_sequencer #(
    parameter int ADDR_BITS = 32,
    parameter int ROW_BITS  = 24
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [3:0]      cfg_data,
    input  logic            req_valid,
    output logic            req_stall,
    input  snwc_pkg::req_t  req,
    output logic            word_valid,
    input  logic            word_stall,
    output snwc_pkg::word_t word
);
    import snwc_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  push, q_full, q_pop, q_empty;
    desc_t push_data, q_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_PAGE_LOG:
                begin
                    if (cfg_data < 4'd9)
                        cfg_next.page_log = 4'd9;
                    else if (cfg_data > 4'd12)
                        cfg_next.page_log = 4'd12;
                    else
                        cfg_next.page_log = cfg_data;
                end
                CFG_BLOCK_LOG:
                begin
                    if (cfg_data < 4'd4)
                        cfg_next.block_log = 4'd4;
                    else if (cfg_data > 4'd8)
                        cfg_next.block_log = 4'd8;
                    else
                        cfg_next.block_log = cfg_data;
                end
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.page_log  <= 4'd11;
            cfg_reg.block_log <= 4'd6;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign req_stall = q_full;

    snwc_front #(
        .ADDR_BITS (ADDR_BITS),
        .ROW_BITS  (ROW_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req       (req),
        .q_full    (q_full),
        .push      (push),
        .desc      (push_data)
    );

    snwc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    snwc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_data     (q_data),
        .q_pop      (q_pop),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .word       (word)
    );

endmodule

>>> tb/sv/snwc_word_checker.sv
// ----------------------------------------------------------------------------
// snwc_word_checker
// Watches the request, configuration and command-word ports of the SPI NAND
// write-combining sequencer. Works out the command words that each accepted
// request must produce and compares every word leaving the block, field by
// field, with the oldest one still owed. Hands back the mismatch count and
// the number of words still owed.
// ----------------------------------------------------------------------------
module snwc_word_checker (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic             cfg_index,
    input  logic [3:0]       cfg_data,
    input  logic             req_valid,
    input  logic             req_stall,
    input  snwc_pkg::req_t   req,
    input  logic             word_valid,
    input  logic             word_stall,
    input  snwc_pkg::word_t  word,
    output int               mismatches,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import snwc_pkg::*;

    localparam int       MAX_WORDS      = 10;
    localparam int       PAGE_LOG_MIN   = 9;
    localparam int       PAGE_LOG_MAX   = 12;
    localparam int       BLOCK_LOG_MIN  = 4;
    localparam int       BLOCK_LOG_MAX  = 8;
    localparam int       ECC_REPAIR_MIN = 1;
    localparam int       ECC_REPAIR_MAX = 3;

    logic [3:0]       page_log_reg;
    logic [3:0]       block_log_reg;
    logic             page_cache_dirty;
    logic [ADDR_W-1:0] load_ptr;
    logic [ADDR_W-1:0] page_start;
    logic [ROW_W-1:0] cached_row;
    logic             cached_row_ok;
    logic             device_busy;
    word_t            owed_words[$];
    int               words_this_req;
    int               fault_count;

    function automatic int page_bits();
        if (int'(page_log_reg) < PAGE_LOG_MIN)
        begin
            return PAGE_LOG_MIN;
        end
        if (int'(page_log_reg) > PAGE_LOG_MAX)
        begin
            return PAGE_LOG_MAX;
        end
        return int'(page_log_reg);
    endfunction

    function automatic int block_bits();
        if (int'(block_log_reg) < BLOCK_LOG_MIN)
        begin
            return BLOCK_LOG_MIN;
        end
        if (int'(block_log_reg) > BLOCK_LOG_MAX)
        begin
            return BLOCK_LOG_MAX;
        end
        return int'(block_log_reg);
    endfunction

    function automatic logic [ROW_W-1:0] row_of(logic [ADDR_W-1:0] a);
        return ROW_W'(a >> page_bits());
    endfunction

    function automatic logic [COL_W-1:0] column_of(logic [ADDR_W-1:0] a);
        return COL_W'(a & ((32'd1 << page_bits()) - 32'd1));
    endfunction

    function automatic void push_word(logic [7:0] op, logic [ROW_W-1:0] row,
                                      logic [COL_W-1:0] col, logic [CNT_W-1:0] cnt,
                                      logic [7:0] fa, logic [7:0] fv);
        word_t w;
        if (words_this_req >= MAX_WORDS)
        begin
            return;
        end
        w.opcode        = op;
        w.row_address   = row;
        w.column        = col;
        w.byte_count    = cnt;
        w.feature_addr  = fa;
        w.feature_value = fv;
        w.last          = 1'b0;
        owed_words.push_back(w);
        words_this_req++;
    endfunction

    function automatic void poll_if_busy();
        if (device_busy)
        begin
            push_word(OP_GET_FEATURE, '0, '0, '0, FEAT_STATUS, '0);
            device_busy = 1'b0;
        end
    endfunction

    function automatic void write_enable_word();
        push_word(OP_WRITE_ENABLE, '0, '0, '0, '0, '0);
        device_busy = 1'b1;
    endfunction

    function automatic void commit_cache();
        logic [ROW_W-1:0] row;
        row = row_of(page_start);
        poll_if_busy();
        push_word(OP_PROGRAM_EXEC, row, '0, '0, '0, '0);
        device_busy      = 1'b1;
        cached_row       = row;
        cached_row_ok    = 1'b1;
        page_cache_dirty = 1'b0;
    endfunction

    function automatic void expand_write(logic [ADDR_W-1:0] addr, logic [CNT_W-1:0] len);
        logic [COL_W-1:0] col;
        int               room;
        int               take;
        if (len == '0)
        begin
            return;
        end
        poll_if_busy();
        write_enable_word();
        if (!page_cache_dirty)
        begin
            page_start = addr;
            load_ptr   = addr;
        end
        col  = column_of(load_ptr);
        room = (1 << page_bits()) - int'(col);
        take = (int'(len) < room) ? int'(len) : room;
        push_word(page_cache_dirty ? OP_RANDOM_LOAD : OP_PROGRAM_LOAD, '0, col,
                  CNT_W'(take), '0, '0);
        page_cache_dirty = 1'b1;
        load_ptr         = load_ptr + ADDR_W'(take);
        if (column_of(load_ptr) == '0)
        begin
            poll_if_busy();
            write_enable_word();
            commit_cache();
            page_start = load_ptr;
        end
    endfunction

    function automatic void expand_read(logic [ADDR_W-1:0] addr, logic [CNT_W-1:0] len);
        logic [ROW_W-1:0] target;
        logic [COL_W-1:0] col;
        int               room;
        logic             dirty_before;
        logic             moved;
        target       = row_of(addr);
        col          = column_of(addr);
        room         = (1 << page_bits()) - int'(col);
        dirty_before = page_cache_dirty;
        if (page_cache_dirty)
        begin
            commit_cache();
        end
        moved = !cached_row_ok || (cached_row != target);
        if (dirty_before || moved)
        begin
            poll_if_busy();
        end
        if (moved)
        begin
            cached_row_ok = 1'b0;
            push_word(OP_PAGE_READ, target, '0, '0, '0, '0);
            device_busy = 1'b1;
            poll_if_busy();
            cached_row    = target;
            cached_row_ok = 1'b1;
        end
        poll_if_busy();
        push_word(OP_READ_CACHE, '0, col, CNT_W'((int'(len) < room) ? int'(len) : room),
                  '0, '0);
    endfunction

    function automatic void expand_erase(logic [ADDR_W-1:0] addr);
        logic [31:0] keep;
        keep = ~((32'd1 << block_bits()) - 32'd1);
        poll_if_busy();
        write_enable_word();
        push_word(OP_BLOCK_ERASE, row_of(addr) & ROW_W'(keep), '0, '0, '0, '0);
        device_busy = 1'b1;
    endfunction

    function automatic void expand_ecc_recovery(logic [2:0] code);
        if (int'(code) < ECC_REPAIR_MIN || int'(code) > ECC_REPAIR_MAX)
        begin
            return;
        end
        push_word(OP_RESET, '0, '0, '0, '0, '0);
        device_busy = 1'b1;
        poll_if_busy();
        push_word(OP_SET_FEATURE, '0, '0, '0, FEAT_LOCK, LOCK_NONE);
        push_word(OP_SET_FEATURE, '0, '0, '0, FEAT_CONFIG, CONFIG_ECC_ON);
    endfunction

    function automatic void expand_request(req_t r);
        words_this_req = 0;
        case (r.command)
            CMD_WRITE: expand_write(r.address, r.length);
            CMD_READ:  expand_read(r.address, r.length);
            CMD_ERASE: expand_erase(r.address);
            CMD_FLUSH:
            begin
                if (page_cache_dirty)
                begin
                    commit_cache();
                end
            end
            CMD_ECC:   expand_ecc_recovery(r.ecc_code);
            default:   ;
        endcase
        if (words_this_req > 0)
        begin
            owed_words[owed_words.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic int field_mismatch(string name, logic [31:0] want, logic [31:0] got);
        if (want === got)
        begin
            return 0;
        end
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        return 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        word_t owed;
        if (!rst_n)
        begin
            page_log_reg     = 4'd11;
            block_log_reg    = 4'd6;
            page_cache_dirty = 1'b0;
            load_ptr         = '0;
            page_start       = '0;
            cached_row       = '0;
            cached_row_ok    = 1'b0;
            device_busy      = 1'b1;
            owed_words.delete();
            fault_count      = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (word_valid && !word_stall)
            begin
                if (owed_words.size() == 0)
                begin
                    $error("unexpected command word, opcode 0x%0h", word.opcode);
                    fault_count++;
                end
                else
                begin
                    owed = owed_words.pop_front();
                    fault_count += field_mismatch("opcode", owed.opcode, word.opcode);
                    fault_count += field_mismatch("row_address", owed.row_address,
                                                  word.row_address);
                    fault_count += field_mismatch("column", owed.column, word.column);
                    fault_count += field_mismatch("byte_count", owed.byte_count,
                                                  word.byte_count);
                    fault_count += field_mismatch("feature_addr", owed.feature_addr,
                                                  word.feature_addr);
                    fault_count += field_mismatch("feature_value", owed.feature_value,
                                                  word.feature_value);
                    fault_count += field_mismatch("last", owed.last, word.last);
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CFG_PAGE_LOG)
                begin
                    page_log_reg = cfg_data;
                end
                else
                begin
                    block_log_reg = cfg_data;
                end
            end
            if (req_valid && !req_stall)
            begin
                expand_request(req);
            end
            mismatches  <= fault_count;
            outstanding <= owed_words.size();
        end
    end

endmodule

>>> tb/sv/spi_nand_write_combining_sequencer_tb.sv
// ----------------------------------------------------------------------------
// spi_nand_write_combining_sequencer_tb
// Drives write, read, erase, flush and ECC-report requests into the
// sequencer under several page and block geometries, with random gaps on
// the request side and random stalls on the command-word side. A directed
// opening covers the corner cases; random traffic with address locality
// follows. The word checker scores every command word.
// ----------------------------------------------------------------------------
module spi_nand_write_combining_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import snwc_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int SETTLE_CYCLES  = 20;
    localparam int PHASES         = 6;
    localparam int PHASE_REQUESTS = 33;

    logic             clk        = 1'b0;
    logic             rst_n      = 1'b0;
    logic             cfg_we     = 1'b0;
    logic             cfg_index  = 1'b0;
    logic [3:0]       cfg_data   = '0;
    logic             req_valid  = 1'b0;
    logic             req_stall;
    req_t             req        = '0;
    logic             word_valid;
    logic             word_stall = 1'b0;
    word_t            word;
    int               mismatches;
    int               outstanding;
    int               cycle_count = 0;
    logic             sender_idles   = 1'b1;
    logic             receiver_idles = 1'b1;
    logic [ADDR_W-1:0] hot_addr      = '0;

    logic [3:0] phase_page  [0:PHASES-1] = '{4'd9, 4'd12, 4'd0, 4'd15, 4'd10, 4'd11};
    logic [3:0] phase_block [0:PHASES-1] = '{4'd4, 4'd8, 4'd15, 4'd0, 4'd5, 4'd7};
    logic       phase_idles [0:PHASES-1] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

    spi_nand_write_combining_sequencer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .word_valid (word_valid),
        .word_stall (word_stall),
        .word       (word)
    );

    snwc_word_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .word_valid  (word_valid),
        .word_stall  (word_stall),
        .word        (word),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (receiver_idles && $urandom_range(0, 5) == 0)
            begin
                word_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
                word_stall <= 1'b0;
            end
        end
    end

    function automatic req_t make_req(logic [2:0] command, logic [ADDR_W-1:0] address,
                                      logic [CNT_W-1:0] length, logic [2:0] ecc_code);
        req_t r;
        r.command  = command;
        r.address  = address;
        r.length   = length;
        r.ecc_code = ecc_code;
        return r;
    endfunction

    function automatic logic [CNT_W-1:0] random_length();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return CNT_W'($urandom());
            2:       return CNT_W'($urandom_range(1024, 4096));
            default: return CNT_W'($urandom_range(1, 300));
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] random_address();
        if ($urandom_range(0, 7) == 0)
        begin
            hot_addr = $urandom();
        end
        if ($urandom_range(0, 2) == 0)
        begin
            return $urandom();
        end
        return hot_addr ^ ADDR_W'($urandom_range(0, 8191));
    endfunction

    function automatic req_t random_request();
        req_t r;
        int   pick;
        pick       = $urandom_range(0, 99);
        r.address  = random_address();
        r.length   = random_length();
        r.ecc_code = 3'($urandom());
        if (pick < 40)
        begin
            r.command = CMD_WRITE;
        end
        else if (pick < 65)
        begin
            r.command = CMD_READ;
        end
        else if (pick < 74)
        begin
            r.command = CMD_ERASE;
        end
        else if (pick < 84)
        begin
            r.command = CMD_FLUSH;
        end
        else if (pick < 94)
        begin
            r.command = CMD_ECC;
        end
        else
        begin
            r.command = CMD_ECC + 3'($urandom_range(1, 3));
        end
        return r;
    endfunction

    task automatic send_request(input req_t r);
        if (sender_idles && $urandom_range(0, 3) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (req_stall);
    endtask

    // hold requests until every owed word has left, then let the pipe empty
    task automatic settle();
        req_valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_geometry(input logic [3:0] page_log, input logic [3:0] block_log);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_PAGE_LOG;
        cfg_data  <= page_log;
        @(posedge clk);
        cfg_index <= CFG_BLOCK_LOG;
        cfg_data  <= block_log;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(make_req(CMD_WRITE, 32'h0000_0000, 13'd0, 3'd0));
        send_request(make_req(CMD_FLUSH, 32'h0000_0000, 13'd0, 3'd0));
        send_request(make_req(CMD_ECC, 32'h0000_0000, 13'd0, 3'd0));
        send_request(make_req(CMD_ECC, 32'hFFFF_FFFF, 13'h1FFF, 3'd7));
        send_request(make_req(CMD_ECC + 3'd1, 32'hFFFF_FFFF, 13'h1FFF, 3'd7));
        send_request(make_req(CMD_ECC + 3'd3, 32'h0000_0000, 13'd0, 3'd1));
        send_request(make_req(CMD_WRITE, 32'h0000_0100, 13'd16, 3'd0));
        send_request(make_req(CMD_WRITE, 32'hFFFF_0000, 13'd32, 3'd0));
        send_request(make_req(CMD_WRITE, 32'h0000_0000, 13'h1FFF, 3'd0));
        send_request(make_req(CMD_READ, 32'hFFFF_FFFF, 13'h1FFF, 3'd0));
        send_request(make_req(CMD_READ, 32'hFFFF_FF00, 13'd4, 3'd0));
        send_request(make_req(CMD_WRITE, 32'h0000_0040, 13'd100, 3'd0));
        send_request(make_req(CMD_READ, 32'h0000_0040, 13'd0, 3'd0));
        send_request(make_req(CMD_WRITE, 32'h0000_1000, 13'd5, 3'd0));
        send_request(make_req(CMD_FLUSH, 32'h0000_0000, 13'd0, 3'd0));
        send_request(make_req(CMD_ERASE, 32'hFFFF_FFFF, 13'd0, 3'd0));
        send_request(make_req(CMD_ERASE, 32'h0000_0000, 13'd0, 3'd0));
        send_request(make_req(CMD_ECC, 32'h0000_0000, 13'd0, 3'd1));
        send_request(make_req(CMD_ECC, 32'h0000_0000, 13'd0, 3'd2));
        send_request(make_req(CMD_ECC, 32'h0000_0000, 13'd0, 3'd3));
        send_request(make_req(CMD_WRITE, 32'h0000_07FF, 13'd1, 3'd0));
        send_request(make_req(CMD_READ, 32'h0000_0000, 13'd4096, 3'd0));

        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            load_geometry(phase_page[p], phase_block[p]);
            sender_idles   = phase_idles[p];
            receiver_idles = phase_idles[p];
            for (int i = 0; i < PHASE_REQUESTS; i++)
            begin
                send_request(random_request());
            end
        end

        settle();
        if (mismatches == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
